### sv/rgbgp_pkg.sv
// shared constants, item types and the level saturation function for rgb_gamma_pwm_unit
// no dependencies
package rgbgp_pkg;

	// duty resolution: full scale is 2^DUTY_BITS, duties span 0..full scale
	localparam int unsigned DUTY_BITS = 8;
	localparam int unsigned DUTY_W    = DUTY_BITS + 1;
	localparam int unsigned LEVEL_W   = 9;
	localparam int unsigned SAT_W     = (LEVEL_W > DUTY_W) ? LEVEL_W : DUTY_W;
	localparam int unsigned FULL      = 1 << DUTY_BITS;
	localparam int unsigned PEND_RST  = FULL - 1;

	// gamma datapath widths
	localparam int unsigned SQ_W   = 2 * DUTY_W;
	localparam int unsigned PROD_W = 3 * DUTY_W;
	localparam int unsigned GAM_SH = 2 * DUTY_BITS - 1;

	// channels
	localparam int unsigned NCH  = 3;
	localparam int unsigned CH_W = 2;

	// queue sizing
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef logic [DUTY_W-1:0] duty_t;

	typedef struct packed {
		logic  set_color;
		duty_t red;
		duty_t green;
		duty_t blue;
		duty_t bright;
	} cmd_t;

	typedef struct packed {
		logic pin_red;
		logic pin_green;
		logic pin_blue;
		logic period_start;
	} res_t;

	function automatic duty_t sat_level(input logic [LEVEL_W-1:0] lv);
		logic [SAT_W-1:0] v;
		begin
			v = SAT_W'(lv);
			if (v > SAT_W'(FULL)) begin
				v = SAT_W'(FULL);
			end
			return DUTY_W'(v);
		end
	endfunction

endpackage

### sv/rgbgp_front.sv
// front end: takes input items, saturates the levels and holds them in a short command queue
// depends on rgbgp_pkg
module rgbgp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             cmd,
	input  logic [rgbgp_pkg::LEVEL_W-1:0]    red_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0]    green_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0]    blue_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0]    bright_level,
	output logic                             q_vld,
	output rgbgp_pkg::cmd_t                  q_head,
	input  logic                             q_take
);

	rgbgp_pkg::cmd_t                    mem_q [rgbgp_pkg::Q_DEPTH];
	logic [rgbgp_pkg::Q_PTR_W-1:0]      wptr_q;
	logic [rgbgp_pkg::Q_PTR_W-1:0]      rptr_q;
	logic [rgbgp_pkg::Q_CNT_W-1:0]      cnt_q;
	logic                               wr_en;
	rgbgp_pkg::cmd_t                    wr_data;

	assign full   = (cnt_q == rgbgp_pkg::Q_CNT_W'(rgbgp_pkg::Q_DEPTH));
	assign q_vld  = (cnt_q != '0);
	assign q_head = mem_q[rptr_q];
	assign wr_en  = push && !full;

	// classify and saturate on the way in
	always_comb begin
		wr_data.set_color = (cmd == rgbgp_pkg::CMD_SET);
		wr_data.red       = rgbgp_pkg::sat_level(red_level);
		wr_data.green     = rgbgp_pkg::sat_level(green_level);
		wr_data.blue      = rgbgp_pkg::sat_level(blue_level);
		wr_data.bright    = rgbgp_pkg::sat_level(bright_level);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				if (wptr_q == rgbgp_pkg::Q_PTR_W'(rgbgp_pkg::Q_DEPTH - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + rgbgp_pkg::Q_PTR_W'(1);
				end
			end
			if (q_take) begin
				if (rptr_q == rgbgp_pkg::Q_PTR_W'(rgbgp_pkg::Q_DEPTH - 1)) begin
					rptr_q <= '0;
				end else begin
					rptr_q <= rptr_q + rgbgp_pkg::Q_PTR_W'(1);
				end
			end
			if (wr_en && !q_take) begin
				cnt_q <= cnt_q + rgbgp_pkg::Q_CNT_W'(1);
			end else if (!wr_en && q_take) begin
				cnt_q <= cnt_q - rgbgp_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

### sv/rgbgp_outq.sv
// result queue between the pwm back end and the output ports
// depends on rgbgp_pkg
module rgbgp_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_push,
	input  rgbgp_pkg::res_t res,
	output logic            res_full,
	output logic            empty,
	input  logic            pop,
	output rgbgp_pkg::res_t head
);

	rgbgp_pkg::res_t                    mem_q [rgbgp_pkg::Q_DEPTH];
	logic [rgbgp_pkg::Q_PTR_W-1:0]      wptr_q;
	logic [rgbgp_pkg::Q_PTR_W-1:0]      rptr_q;
	logic [rgbgp_pkg::Q_CNT_W-1:0]      cnt_q;
	logic                               rd_en;

	assign res_full = (cnt_q == rgbgp_pkg::Q_CNT_W'(rgbgp_pkg::Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head     = mem_q[rptr_q];
	assign rd_en    = pop && !empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			mem_q[wptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (res_push) begin
				if (wptr_q == rgbgp_pkg::Q_PTR_W'(rgbgp_pkg::Q_DEPTH - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + rgbgp_pkg::Q_PTR_W'(1);
				end
			end
			if (rd_en) begin
				if (rptr_q == rgbgp_pkg::Q_PTR_W'(rgbgp_pkg::Q_DEPTH - 1)) begin
					rptr_q <= '0;
				end else begin
					rptr_q <= rptr_q + rgbgp_pkg::Q_PTR_W'(1);
				end
			end
			if (res_push && !rd_en) begin
				cnt_q <= cnt_q + rgbgp_pkg::Q_CNT_W'(1);
			end else if (!res_push && rd_en) begin
				cnt_q <= cnt_q - rgbgp_pkg::Q_CNT_W'(1);
			end
		end
	end

endmodule

### sv/rgbgp_back.sv
// back end: pwm period counter, duty registers and the shared-multiplier gamma sequencer
// depends on rgbgp_pkg
module rgbgp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_vld,
	input  rgbgp_pkg::cmd_t cmd,
	output logic            cmd_take,
	input  logic            res_full,
	output logic            res_push,
	output rgbgp_pkg::res_t res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQ,
		ST_CUBE,
		ST_SCALE
	} state_t;

	state_t                           state_q;
	rgbgp_pkg::duty_t                 tick_q;
	rgbgp_pkg::duty_t                 active_q  [rgbgp_pkg::NCH];
	rgbgp_pkg::duty_t                 pending_q [rgbgp_pkg::NCH];
	logic [rgbgp_pkg::NCH-1:0]        pins_q;
	logic [rgbgp_pkg::CH_W-1:0]       ch_q;

	rgbgp_pkg::duty_t                 lv_q [rgbgp_pkg::NCH];
	rgbgp_pkg::duty_t                 bright_q;
	logic [rgbgp_pkg::PROD_W-1:0]     prod_q;

	logic [rgbgp_pkg::NCH-1:0]        pins_nxt;
	logic                             reload;
	rgbgp_pkg::duty_t                 lv_cur;
	logic [rgbgp_pkg::SQ_W-1:0]       op_a;
	rgbgp_pkg::duty_t                 op_b;
	logic [rgbgp_pkg::PROD_W-1:0]     prod;
	logic [rgbgp_pkg::DUTY_W:0]       gamma_sum;
	rgbgp_pkg::duty_t                 gamma;
	rgbgp_pkg::duty_t                 scaled;

	assign cmd_take = cmd_vld && !res_full && (state_q == ST_IDLE);
	assign reload   = (tick_q == rgbgp_pkg::duty_t'(0));

	// pin update for a tick
	always_comb begin
		for (int i = 0; i < rgbgp_pkg::NCH; i++) begin
			if (reload) begin
				pins_nxt[i] = 1'b0;
			end else begin
				pins_nxt[i] = pins_q[i] | (tick_q == active_q[i]);
			end
		end
	end

	// one result per command, pushed when it is taken
	assign res_push = cmd_take;
	always_comb begin
		if (cmd.set_color) begin
			res.pin_red      = pins_q[0];
			res.pin_green    = pins_q[1];
			res.pin_blue     = pins_q[2];
			res.period_start = 1'b0;
		end else begin
			res.pin_red      = pins_nxt[0];
			res.pin_green    = pins_nxt[1];
			res.pin_blue     = pins_nxt[2];
			res.period_start = reload;
		end
	end

	// shared multiplier: x*x, then *x, then gamma*bright
	assign lv_cur    = lv_q[ch_q];
	assign gamma_sum = (rgbgp_pkg::DUTY_W + 1)'(prod_q >> rgbgp_pkg::GAM_SH)
		+ (rgbgp_pkg::DUTY_W + 1)'(1);
	assign gamma     = gamma_sum[rgbgp_pkg::DUTY_W:1];

	always_comb begin
		unique case (state_q)
			ST_CUBE: begin
				op_a = prod_q[rgbgp_pkg::SQ_W-1:0];
				op_b = lv_cur;
			end
			ST_SCALE: begin
				op_a = rgbgp_pkg::SQ_W'(gamma);
				op_b = bright_q;
			end
			default: begin
				op_a = rgbgp_pkg::SQ_W'(lv_cur);
				op_b = lv_cur;
			end
		endcase
	end

	assign prod   = rgbgp_pkg::PROD_W'(op_a) * rgbgp_pkg::PROD_W'(op_b);
	assign scaled = rgbgp_pkg::DUTY_W'(prod >> rgbgp_pkg::DUTY_BITS);

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.set_color) begin
			lv_q[0]  <= cmd.red;
			lv_q[1]  <= cmd.green;
			lv_q[2]  <= cmd.blue;
			bright_q <= cmd.bright;
		end
		if (state_q == ST_SQ || state_q == ST_CUBE) begin
			prod_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_q  <= '0;
			pins_q  <= '0;
			ch_q    <= '0;
			for (int i = 0; i < rgbgp_pkg::NCH; i++) begin
				active_q[i]  <= '0;
				pending_q[i] <= rgbgp_pkg::duty_t'(rgbgp_pkg::PEND_RST);
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						if (cmd.set_color) begin
							state_q <= ST_SQ;
							ch_q    <= '0;
						end else begin
							pins_q <= pins_nxt;
							if (reload) begin
								tick_q <= rgbgp_pkg::duty_t'(rgbgp_pkg::FULL);
								for (int i = 0; i < rgbgp_pkg::NCH; i++) begin
									active_q[i] <= pending_q[i];
								end
							end else begin
								tick_q <= tick_q - rgbgp_pkg::duty_t'(1);
							end
						end
					end
				end
				ST_SQ: begin
					state_q <= ST_CUBE;
				end
				ST_CUBE: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					pending_q[ch_q] <= scaled;
					if (ch_q == rgbgp_pkg::CH_W'(rgbgp_pkg::NCH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						ch_q    <= ch_q + rgbgp_pkg::CH_W'(1);
						state_q <= ST_SQ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd_take)
		else $error("command taken while gamma sequencer busy");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= rgbgp_pkg::duty_t'(rgbgp_pkg::FULL))
		else $error("period counter above full scale");

	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && !cmd.set_color && reload) |=>
		(tick_q == rgbgp_pkg::duty_t'(rgbgp_pkg::FULL) && pins_q == '0))
		else $error("period start did not reload counter and clear pins");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q < rgbgp_pkg::CH_W'(rgbgp_pkg::NCH))
		else $error("channel index out of range");

endmodule

### sv/rgb_gamma_pwm_unit.sv
// top level of the three-channel gamma-corrected led pwm driver
// depends on rgbgp_pkg, rgbgp_front, rgbgp_back, rgbgp_outq
//
// three-channel led pwm with cube-law gamma and brightness. an item with cmd high sets the
// colour: each level and the brightness saturate to full scale (256), each channel is gamma
// corrected as ((x^3*256 >> 23) + 1) >> 1, scaled by brightness >> 8 and parked in a pending
// duty register; it takes effect at the next period start. an item with cmd low is one pwm
// tick of a 257-tick period: a down-counter reloads to 256 at zero (copying pending into
// active duties, all pins low, period_start high), otherwise a pin goes high when the counter
// equals its duty. every item yields exactly one result with the pin levels after it. both
// sides are queues: push/full on the input, empty/pop on the output, two items deep each.
// ticks run at one item per clock while the back end is idle and the output queue is not
// full; a set-colour item keeps the back end busy after it is taken, and no next item
// enters the back end meanwhile, since one shared multiplier does three steps per channel
// (square, cube, brightness scale) over three channels; the front queue keeps accepting
// meanwhile until full. an accepted item is registered in the front queue, taken from its
// head by the idle back end, and its result is registered in the output queue to be popped.
// after reset the first tick starts a period and pending duties are 255; no clearing pass is needed.
module rgb_gamma_pwm_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          cmd,
	input  logic [rgbgp_pkg::LEVEL_W-1:0] red_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0] green_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0] blue_level,
	input  logic [rgbgp_pkg::LEVEL_W-1:0] bright_level,
	output logic                          empty,
	input  logic                          pop,
	output logic                          pin_red,
	output logic                          pin_green,
	output logic                          pin_blue,
	output logic                          period_start
);

	// command queue between front and back
	logic            q_vld;
	rgbgp_pkg::cmd_t q_head;
	logic            q_take;

	// result path from back into the output queue
	logic            res_full;
	logic            res_push;
	rgbgp_pkg::res_t res;
	rgbgp_pkg::res_t head;

	// front: accept, saturate, classify tick vs set-colour
	rgbgp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.bright_level (bright_level),
		.q_vld        (q_vld),
		.q_head       (q_head),
		.q_take       (q_take)
	);

	// back: period counter, duties, pins and the gamma sequencer
	rgbgp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_vld  (q_vld),
		.cmd      (q_head),
		.cmd_take (q_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	// output queue decouples the back end from the consumer
	rgbgp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	assign pin_red      = head.pin_red;
	assign pin_green    = head.pin_green;
	assign pin_blue     = head.pin_blue;
	assign period_start = head.period_start;

endmodule
